// ===== hdl/qfe_pkg.sv =====
// ----------------------------------------------------------------------------
// qfe_pkg: shared types and constants for the quoted field extractor
// Transaction payloads, the result group passed from the parser to the
// output buffer, parse phases and configuration register indexes.
// ----------------------------------------------------------------------------
package qfe_pkg;

  // Special byte values
  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] TabByte   = 8'h09;
  localparam logic [7:0] LetterT   = 8'h74;
  localparam logic [7:0] SpaceByte = 8'h20;

  // Register reset values
  localparam logic [7:0] DelimiterReset = 8'd124;
  localparam logic [7:0] QuoteReset     = 8'd34;
  localparam logic       TrimReset      = 1'b1;

  // Most results one source byte can cause
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    CFG_DELIMITER = 2'd0,
    CFG_QUOTE     = 2'd1,
    CFG_FIELD_IDX = 2'd2,
    CFG_TRIM      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SKIP  = 2'd1,
    PH_COPY  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] space_gap;
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_string;
    logic       field_found;
  } out_item_t;

  // Results of one source byte, item[0] delivered first
  typedef struct packed {
    logic [1:0]                 count;
    out_item_t [MaxResults-1:0] item;
  } rslt_group_t;

  function automatic rslt_group_t push_result(input rslt_group_t grp,
                                              input out_item_t   it);
    rslt_group_t g;
    g = grp;
    if (g.count < 2'(MaxResults)) begin
      g.item[g.count] = it;
      g.count         = g.count + 2'd1;
    end
    return g;
  endfunction

endpackage

// ===== hdl/qfe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qfe_cfg_regs: configuration register file
// Four write-only registers loaded from the configuration channel.
// ----------------------------------------------------------------------------
module qfe_cfg_regs #(
  parameter int unsigned FIELD_INDEX_BITS = 8,
  parameter int unsigned CFG_DATA_BITS    = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  qfe_pkg::cfg_reg_e           wr_idx_i,
  input  logic [CFG_DATA_BITS-1:0]    wr_data_i,
  output logic [7:0]                  delim_o,
  output logic [7:0]                  quote_o,
  output logic [FIELD_INDEX_BITS-1:0] field_idx_o,
  output logic                        trim_o
);
  import qfe_pkg::*;

  logic [7:0]                  delim_q, quote_q;
  logic [FIELD_INDEX_BITS-1:0] field_idx_q;
  logic                        trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q     <= DelimiterReset;
      quote_q     <= QuoteReset;
      field_idx_q <= '0;
      trim_q      <= TrimReset;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_DELIMITER: delim_q     <= wr_data_i[7:0];
        CFG_QUOTE:     quote_q     <= wr_data_i[7:0];
        CFG_FIELD_IDX: field_idx_q <= wr_data_i[FIELD_INDEX_BITS-1:0];
        CFG_TRIM:      trim_q      <= wr_data_i[0];
        default:       ;
      endcase
    end
  end

  assign delim_o     = delim_q;
  assign quote_o     = quote_q;
  assign field_idx_o = field_idx_q;
  assign trim_o      = trim_q;

endmodule

// ===== hdl/qfe_parse.sv =====
// ----------------------------------------------------------------------------
// qfe_parse: per-byte field parser
// Holds the string scan state and, for one source byte, works out the next
// state and the group of results (up to three) that the byte causes.
// ----------------------------------------------------------------------------
module qfe_parse #(
  parameter int unsigned FIELD_INDEX_BITS = 8,
  parameter int unsigned SPACE_COUNT_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  qfe_pkg::in_item_t           item_i,
  input  logic [7:0]                  delim_i,
  input  logic [7:0]                  quote_i,
  input  logic [FIELD_INDEX_BITS-1:0] field_idx_i,
  input  logic                        trim_i,
  output qfe_pkg::rslt_group_t        group_o
);
  import qfe_pkg::*;

  localparam logic [SPACE_COUNT_BITS-1:0] HeldMax = {SPACE_COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                        emit;
    logic [7:0]                  gap;
    logic [7:0]                  ch;
    logic [SPACE_COUNT_BITS-1:0] held;
    logic                        started;
  } content_t;

  typedef struct packed {
    content_t c;
    logic     inq;
    logic     done;
  } plain_t;

  // Field content byte: trimming holds spaces back and reports them as a gap
  function automatic content_t content_f(input logic [7:0]                  b,
                                         input logic [SPACE_COUNT_BITS-1:0] held,
                                         input logic                        started,
                                         input logic                        trim);
    content_t r;
    r.emit    = 1'b0;
    r.gap     = '0;
    r.ch      = b;
    r.held    = held;
    r.started = started;
    if (!trim) begin
      r.emit = 1'b1;
    end else if (b == SpaceByte) begin
      if (started && (held != HeldMax)) r.held = held + SPACE_COUNT_BITS'(1);
    end else begin
      r.emit    = 1'b1;
      r.gap     = (32'(held) > 32'd255) ? 8'hFF : 8'(held);
      r.held    = '0;
      r.started = 1'b1;
    end
    return r;
  endfunction

  // Unescaped byte inside the field: quote toggles, delimiter ends the field
  function automatic plain_t plain_f(input logic [7:0]                  b,
                                     input logic [SPACE_COUNT_BITS-1:0] held,
                                     input logic                        started,
                                     input logic                        inq,
                                     input logic [7:0]                  d,
                                     input logic [7:0]                  quote,
                                     input logic                        trim);
    plain_t r;
    r.c      = '{emit: 1'b0, gap: 8'd0, ch: b, held: held, started: started};
    r.inq    = inq;
    r.done   = 1'b0;
    if (b == quote) begin
      r.inq = ~inq;
    end else if ((b == d) && !inq) begin
      r.done   = 1'b1;
      r.c.held = '0;
    end else begin
      r.c = content_f(b, held, started, trim);
    end
    return r;
  endfunction

  phase_e                      phase_q, phase_d;
  logic [FIELD_INDEX_BITS-1:0] dseen_q, dseen_d;
  logic                        inq_q, inq_d;
  logic                        esc_q, esc_d;
  logic [SPACE_COUNT_BITS-1:0] held_q, held_d;
  logic                        started_q, started_d;

  logic [7:0]  eff_delim;
  logic [7:0]  b;
  logic        go;
  logic        found;
  content_t    cres;
  plain_t      pres;
  rslt_group_t grp;

  always_comb begin
    eff_delim = (delim_i == LetterT) ? TabByte : delim_i;
    b         = item_i.char_in;
    phase_d   = phase_q;
    dseen_d   = dseen_q;
    inq_d     = inq_q;
    esc_d     = esc_q;
    held_d    = held_q;
    started_d = started_q;
    go        = 1'b0;
    found     = 1'b0;
    cres      = '0;
    pres      = '0;
    grp       = '0;

    // Skip or copy is chosen at the first byte of a string
    if (phase_d == PH_START) begin
      if (eff_delim == 8'd0)              phase_d = PH_SKIP;
      else if (field_idx_i == '0)         phase_d = PH_COPY;
      else                                phase_d = PH_SKIP;
    end

    if (phase_d == PH_SKIP) begin
      if (esc_d) begin
        esc_d = 1'b0;
      end else if (b == Backslash) begin
        esc_d = 1'b1;
      end else if (b == quote_i) begin
        inq_d = ~inq_d;
      end else if (!inq_d && (eff_delim != 8'd0) && (b == eff_delim)) begin
        dseen_d = dseen_d + FIELD_INDEX_BITS'(1);
        if (dseen_d == field_idx_i) begin
          phase_d = PH_COPY;
          inq_d   = 1'b0;
          esc_d   = 1'b0;
        end
      end
    end else if (phase_d == PH_COPY) begin
      go = 1'b1;
      if (esc_d) begin
        esc_d = 1'b0;
        if (b == eff_delim) begin
          // escaped delimiter is field content
          cres      = content_f(b, held_d, started_d, trim_i);
          held_d    = cres.held;
          started_d = cres.started;
          if (cres.emit) begin
            grp = push_result(grp, '{space_gap: cres.gap, out_char: cres.ch,
                                     char_valid: 1'b1, end_of_string: 1'b0,
                                     field_found: 1'b0});
          end
          go = 1'b0;
        end else begin
          // the held backslash goes through as an ordinary byte first
          pres      = plain_f(Backslash, held_d, started_d, inq_d, eff_delim,
                              quote_i, trim_i);
          held_d    = pres.c.held;
          started_d = pres.c.started;
          inq_d     = pres.inq;
          if (pres.done) begin
            phase_d = PH_DONE;
            go      = 1'b0;
          end
          if (pres.c.emit) begin
            grp = push_result(grp, '{space_gap: pres.c.gap, out_char: pres.c.ch,
                                     char_valid: 1'b1, end_of_string: 1'b0,
                                     field_found: 1'b0});
          end
        end
      end
      if (go) begin
        if (b == Backslash) begin
          esc_d = 1'b1;
        end else begin
          pres      = plain_f(b, held_d, started_d, inq_d, eff_delim, quote_i, trim_i);
          held_d    = pres.c.held;
          started_d = pres.c.started;
          inq_d     = pres.inq;
          if (pres.done) phase_d = PH_DONE;
          if (pres.c.emit) begin
            grp = push_result(grp, '{space_gap: pres.c.gap, out_char: pres.c.ch,
                                     char_valid: 1'b1, end_of_string: 1'b0,
                                     field_found: 1'b0});
          end
        end
      end
    end

    if (item_i.last_char) begin
      // a backslash on the last byte is an ordinary byte
      if ((phase_d == PH_COPY) && esc_d) begin
        esc_d     = 1'b0;
        pres      = plain_f(Backslash, held_d, started_d, inq_d, eff_delim,
                            quote_i, trim_i);
        held_d    = pres.c.held;
        started_d = pres.c.started;
        inq_d     = pres.inq;
        if (pres.done) phase_d = PH_DONE;
        if (pres.c.emit) begin
          grp = push_result(grp, '{space_gap: pres.c.gap, out_char: pres.c.ch,
                                   char_valid: 1'b1, end_of_string: 1'b0,
                                   field_found: 1'b0});
        end
      end
      found = (eff_delim != 8'd0) && ((phase_d == PH_COPY) || (phase_d == PH_DONE));
      grp = push_result(grp, '{space_gap: 8'd0, out_char: 8'd0, char_valid: 1'b0,
                               end_of_string: 1'b1, field_found: found});
      phase_d   = PH_START;
      dseen_d   = '0;
      inq_d     = 1'b0;
      esc_d     = 1'b0;
      held_d    = '0;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      dseen_q   <= '0;
      inq_q     <= 1'b0;
      esc_q     <= 1'b0;
      held_q    <= '0;
      started_q <= 1'b0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      dseen_q   <= dseen_d;
      inq_q     <= inq_d;
      esc_q     <= esc_d;
      held_q    <= held_d;
      started_q <= started_d;
    end
  end

  assign group_o = grp;

endmodule

// ===== hdl/qfe_result_buf.sv =====
// ----------------------------------------------------------------------------
// qfe_result_buf: result group register and output drain
// Holds the results of one source byte and hands them out one per
// transaction. Reports free when a new group can load this cycle.
// ----------------------------------------------------------------------------
module qfe_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  qfe_pkg::rslt_group_t group_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qfe_pkg::out_item_t   out_item_o
);
  import qfe_pkg::*;

  out_item_t [MaxResults-1:0] items_q;
  logic [1:0]                 rem_q;
  logic [1:0]                 head_q;
  logic                       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign out_item_o  = items_q[head_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (rem_q == 2'd0) || ((rem_q == 2'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      head_q <= 2'd0;
    end else if (load_i) begin
      rem_q  <= group_i.count;
      head_q <= 2'd0;
    end else if (pop) begin
      rem_q  <= rem_q - 2'd1;
      head_q <= head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) items_q <= group_i.item;
  end

endmodule

// ===== hdl/quoted_field_extract.sv =====
// ----------------------------------------------------------------------------
// quoted_field_extract: streaming extraction of one delimited field
// Scans a byte stream, one byte per input transaction, and emits the bytes
// of the selected field with quote, escape and space-trim handling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one source byte per
//   transaction, last_char set on the final byte of a string.
//   Output channel (out_valid_o / out_stall_i / out_item_o): field bytes
//   (char_valid = 1, with a space_gap count of deferred spaces under trim),
//   and one end-of-string transaction carrying field_found per string.
//   Configuration channel (cfg_valid_i / cfg_ready_o): always ready; write
//   only while the block is idle. Index 0 delimiter ('t' means tab),
//   1 quote byte, 2 field index, 3 trim enable.
// Timing:
//   A byte is captured into an input register, parsed there by the parser and
//   its results (zero to three) land in the result register when it is free.
//   One byte is taken every cycle as long as each byte gives at most one
//   result and out_stall_i stays low; a byte with more results holds the
//   input while the result register drains them, one per unstalled cycle.
// Reset: registers return to their defaults and the scan state to the start
//   of a string; no results are pending.
// Stall: out_stall_i holds the current result; an empty input register still
//   takes one more byte, then in_stall_o rises until the results drain.
// ----------------------------------------------------------------------------
module quoted_field_extract #(
  parameter int unsigned FIELD_INDEX_BITS = 8,
  parameter int unsigned SPACE_COUNT_BITS = 8,
  localparam int unsigned CfgDataBits = (FIELD_INDEX_BITS > 8) ? FIELD_INDEX_BITS : 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // source bytes
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  qfe_pkg::in_item_t      in_item_i,
  // field bytes and end results
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output qfe_pkg::out_item_t     out_item_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  qfe_pkg::cfg_reg_e      cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);
  import qfe_pkg::*;

  logic [7:0]                  delim;
  logic [7:0]                  quote;
  logic [FIELD_INDEX_BITS-1:0] field_idx;
  logic                        trim;

  in_item_t    in_q;
  logic        in_valid_q;
  logic        buf_free;
  logic        advance;
  logic        in_take;
  rslt_group_t group;

  assign cfg_ready_o = 1'b1;

  // The parser moves the held byte on whenever the result register frees up
  assign advance    = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !buf_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_item_i;
  end

  qfe_cfg_regs #(
    .FIELD_INDEX_BITS(FIELD_INDEX_BITS),
    .CFG_DATA_BITS   (CfgDataBits)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_idx_i   (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .delim_o    (delim),
    .quote_o    (quote),
    .field_idx_o(field_idx),
    .trim_o     (trim)
  );

  qfe_parse #(
    .FIELD_INDEX_BITS(FIELD_INDEX_BITS),
    .SPACE_COUNT_BITS(SPACE_COUNT_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (in_q),
    .delim_i    (delim),
    .quote_i    (quote),
    .field_idx_i(field_idx),
    .trim_i     (trim),
    .group_o    (group)
  );

  qfe_result_buf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .group_i    (group),
    .free_o     (buf_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quoted_field_extract
// Streams short strings through the extractor under changing delimiter,
// quote, field index and trim settings. A scoreboard tracks the scan state
// in parallel and checks each field byte and end-of-string transaction in
// order. The run covers idle and stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import qfe_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainCycles = 8;    // two-stage pipe, with margin
  localparam int unsigned HoldCycles  = 80;   // long receiver hold-off

  // --------------------------------------------------------------------------
  // Scoreboard: running copy of the scan state, FIFO of expected results
  // --------------------------------------------------------------------------
  class extract_scoreboard;
    out_item_t  expected_chars[$];
    int         errors;
    int         checked;

    // register copies
    logic [7:0] delim_r;
    logic [7:0] quote_r;
    logic [7:0] index_r;
    logic       trim_r;

    // scan state
    phase_e     phase;
    logic [7:0] delims_seen;
    logic       in_quote;
    logic       esc_pending;
    logic [7:0] held_spaces;
    logic       started;

    function new();
      delim_r = DelimiterReset;
      quote_r = QuoteReset;
      index_r = 8'd0;
      trim_r  = TrimReset;
      errors  = 0;
      checked = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase       = PH_START;
      delims_seen = 8'd0;
      in_quote    = 1'b0;
      esc_pending = 1'b0;
      held_spaces = 8'd0;
      started     = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [7:0] val);
      case (idx)
        CFG_DELIMITER: delim_r = val;
        CFG_QUOTE:     quote_r = val;
        CFG_FIELD_IDX: index_r = val;
        CFG_TRIM:      trim_r  = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // 't' stands for tab
    function logic [7:0] active_delim();
      return (delim_r == LetterT) ? TabByte : delim_r;
    endfunction

    function void push(logic [7:0] gap, logic [7:0] ch, logic valid, logic eos,
                       logic found);
      out_item_t r;
      r.space_gap     = gap;
      r.out_char      = ch;
      r.char_valid    = valid;
      r.end_of_string = eos;
      r.field_found   = found;
      expected_chars.push_back(r);
    endfunction

    // content byte: spaces are deferred under trim, leading ones dropped
    function void emit_content(logic [7:0] b);
      if (!trim_r) begin
        push(8'd0, b, 1'b1, 1'b0, 1'b0);
        return;
      end
      if (b == SpaceByte) begin
        if (started && held_spaces != 8'hFF) held_spaces = held_spaces + 8'd1;
        return;
      end
      push(held_spaces, b, 1'b1, 1'b0, 1'b0);
      held_spaces = 8'd0;
      started     = 1'b1;
    endfunction

    // quote wins over delimiter when the two are equal
    function void plain_byte(logic [7:0] b);
      if (b == quote_r) begin
        in_quote = ~in_quote;
        return;
      end
      if (b == active_delim() && !in_quote) begin
        phase       = PH_DONE;
        held_spaces = 8'd0;
        return;
      end
      emit_content(b);
    endfunction

    function void copy_byte(logic [7:0] b);
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == active_delim()) begin
          emit_content(b);
          return;
        end
        plain_byte(Backslash);
        if (phase != PH_COPY) return;
      end
      if (b == Backslash) begin
        esc_pending = 1'b1;
        return;
      end
      plain_byte(b);
    endfunction

    function void skip_byte(logic [7:0] b);
      logic [7:0] d;
      d = active_delim();
      if (esc_pending) begin
        esc_pending = 1'b0;
        return;
      end
      if (b == Backslash) begin
        esc_pending = 1'b1;
        return;
      end
      if (b == quote_r) begin
        in_quote = ~in_quote;
        return;
      end
      if (in_quote || d == 8'd0 || b != d) return;
      delims_seen = delims_seen + 8'd1;
      if (delims_seen == index_r) begin
        phase       = PH_COPY;
        in_quote    = 1'b0;
        esc_pending = 1'b0;
      end
    endfunction

    // accepted source byte: queue every result it causes
    function void take_source_byte(in_item_t it);
      logic found;
      if (phase == PH_START) begin
        if (active_delim() == 8'd0) phase = PH_SKIP;
        else phase = (index_r == 8'd0) ? PH_COPY : PH_SKIP;
      end
      if (phase == PH_SKIP) skip_byte(it.char_in);
      else if (phase == PH_COPY) copy_byte(it.char_in);
      if (it.last_char) begin
        if (phase == PH_COPY && esc_pending) begin
          esc_pending = 1'b0;
          plain_byte(Backslash);
        end
        found = (active_delim() != 8'd0) && (phase == PH_COPY || phase == PH_DONE);
        push(8'd0, 8'd0, 1'b0, 1'b1, found);
        clear_string();
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field_result(out_item_t got);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected result char=%02h eos=%b", got.out_char,
                         got.end_of_string));
        return;
      end
      want = expected_chars.pop_front();
      if (got.space_gap !== want.space_gap)
        report($sformatf("#%0d space_gap %0d, want %0d", checked, got.space_gap,
                         want.space_gap));
      if (got.out_char !== want.out_char)
        report($sformatf("#%0d out_char %02h, want %02h", checked, got.out_char,
                         want.out_char));
      if (got.char_valid !== want.char_valid)
        report($sformatf("#%0d char_valid %b, want %b", checked, got.char_valid,
                         want.char_valid));
      if (got.end_of_string !== want.end_of_string)
        report($sformatf("#%0d end_of_string %b, want %b", checked,
                         got.end_of_string, want.end_of_string));
      if (got.field_found !== want.field_found)
        report($sformatf("#%0d field_found %b, want %b", checked, got.field_found,
                         want.field_found));
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  cfg_reg_e   cfg_index_i = CFG_DELIMITER;
  logic [7:0] cfg_data_i  = 8'd0;

  extract_scoreboard sb;

  // handshake pressure knobs, in percent
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  logic       hold_request  = 1'b0;
  int         hold_left     = 0;
  int         cycle_count   = 0;
  int         items_sent    = 0;

  // bench-side copy of the bytes that matter when building strings
  logic [7:0] cur_delim = DelimiterReset;
  logic [7:0] cur_quote = QuoteReset;

  quoted_field_extract dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns period
  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Monitor: both channels sampled at the rising edge. Inputs only move on
  // the falling edge, so the values seen here are settled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_source_byte(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_field_result(out_item_o);
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested. The
  // hold-off is counted here so that the sender keeps pushing meanwhile.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: called at a falling edge, return at a falling edge
  // --------------------------------------------------------------------------

  // One source byte. Valid stays high into the next call when no gap is
  // drawn, so back-to-back transactions need no toggle.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{char_in: b, last_char: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, logic ends_string);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], ends_string && (k == s.len() - 1));
  endtask

  // Block idle: nothing expected, and the pipe has had time to swallow any
  // byte that gives no result.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One write; valid drops for a cycle before the task returns.
  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    if (idx == CFG_DELIMITER) cur_delim = val;
    if (idx == CFG_QUOTE) cur_quote = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(logic [7:0] d, logic [7:0] q, logic [7:0] idx, logic trim);
    write_reg(CFG_DELIMITER, d);
    write_reg(CFG_QUOTE, q);
    write_reg(CFG_FIELD_IDX, idx);
    write_reg(CFG_TRIM, trim);
  endtask

  // Random settings, extremes weighted in; a zero delimiter is left to the
  // directed part.
  task automatic pick_config();
    logic [7:0] d;
    logic [7:0] q;
    logic [7:0] idx;
    case ($urandom_range(0, 5))
      0:       d = "|";
      1:       d = ",";
      2:       d = LetterT;
      3:       d = 8'd1;
      4:       d = 8'hFF;
      default: d = 8'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 4))
      0:       q = "\"";
      1:       q = "'";
      2:       q = 8'h00;
      3:       q = 8'hFF;
      default: q = 8'($urandom_range(0, 255));
    endcase
    idx = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
    set_all(d, q, idx, 1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed content: letters, spaces, quotes, escapes and
  // delimiters, plus the odd arbitrary byte.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 25));
      4:          return SpaceByte;
      5:          return cur_quote;
      6:          return Backslash;
      7, 8:       return (cur_delim == LetterT) ? TabByte : cur_delim;
      default:    return 8'($urandom);
    endcase
  endfunction

  // One string; about one in six is pure noise.
  task automatic send_random_string();
    int   len;
    logic noise;
    len   = $urandom_range(1, 14);
    noise = ($urandom_range(0, 5) == 0);
    for (int k = 0; k < len; k++)
      send_byte(noise ? 8'($urandom) : pick_byte(), k == len - 1);
  endtask

  task automatic random_phase(int n_items, int idle, int stall);
    int stop_at;
    drain();
    pick_config();
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = items_sent + n_items;
    while (items_sent < stop_at) send_random_string();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part, reset settings: '|' delimiter, '"' quote, field 0,
    // trim on. Leading spaces dropped, inner run as a gap, escaped
    // delimiter, quoted delimiter kept, quotes dropped, field end, tail
    // ignored.
    send_text(" a  b\\|\"c|d\"|z", 1'b1);
    // backslash before an ordinary byte is kept; backslash as last byte
    send_text("\\q\\", 1'b1);
    drain();

    // 't' means tab; field 1 with trim off, zero byte and high byte as data
    set_all(LetterT, 8'hFF, 8'd1, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(TabByte, 1'b0);
    send_byte(SpaceByte, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // top of every range: the field never turns up; zero byte opens a quote
    set_all(8'hFF, 8'h00, 8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // zero delimiter: nothing out, field not found
    write_reg(CFG_DELIMITER, 8'h00);
    send_text("ab", 1'b1);
    drain();

    // quote equal to delimiter: the quote meaning wins
    set_all(",", ",", 8'd0, 1'b1);
    send_text("a,b", 1'b1);
    drain();

    // field index lowered below the count in the middle of a string
    write_reg(CFG_QUOTE, "\"");
    write_reg(CFG_FIELD_IDX, 8'd2);
    send_text("a,", 1'b0);
    drain();
    write_reg(CFG_FIELD_IDX, 8'd0);
    send_text("c,d", 1'b1);

    // ---- random part, one phase per idle/stall mix
    random_phase(12, 0, 0);
    random_phase(12, 69, 0);
    random_phase(12, 0, 69);
    random_phase(12, 8, 8);

    // ---- long hold-off while the sender keeps offering bytes, so the
    // result register fills and the input stalls
    drain();
    set_all("|", "\"", 8'd0, 1'b0);
    send_idle_pct = 0;
    stall_pct     = 20;
    @(posedge clk_i);
    hold_request = 1'b1;
    @(negedge clk_i);
    for (int k = 0; k < 30; k++)
      send_byte(8'h41 + 8'(k % 26), k == 29);

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
